// ----- hw/rtl/plwi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// plwi_pkg: shared types and constants of the window intersect engine
// Beat layouts, store entry and write request, configuration bundle, codes.
// ----------------------------------------------------------------------------
package plwi_pkg;

    // store geometry
    localparam int LIST_DEPTH = 1024;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_PROBE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // output mode codes
    localparam logic [1:0] OUT_MATCH    = 2'd0;
    localparam logic [1:0] OUT_NONMATCH = 2'd1;
    localparam logic [1:0] OUT_BOTH     = 2'd2;

    // score mode codes
    localparam logic SCORE_SUM = 1'b0;
    localparam logic SCORE_MAX = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_CHECK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_MIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_MAX     = 3'd6;
    localparam int CFG_DATA_W = 31;

    localparam logic [30:0] WORD_MAX_RESET = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] doc_id;
        logic [30:0] word_id;
        logic [23:0] position;
        logic [15:0] score;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_doc;
        logic [30:0] out_word;
        logic [23:0] out_position;
        logic [15:0] out_score;
        logic        out_matched;
    } t_out_item;

    // one stored first-list posting
    typedef struct packed {
        logic [31:0] doc;
        logic [23:0] pos;
        logic [15:0] score;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_store_wr;

    typedef struct packed {
        logic               score_mode;
        logic [1:0]         output_mode;
        logic               pos_check;
        logic signed [16:0] window_left;
        logic signed [16:0] window_right;
        logic [30:0]        word_min;
        logic [30:0]        word_max;
    } t_cfg;

    // saturating sum or maximum of two scores
    function automatic logic [15:0] combine_scores(input logic mode,
                                                   input logic [15:0] a,
                                                   input logic [15:0] b);
        logic [16:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (mode == SCORE_MAX) begin
            return (a > b) ? a : b;
        end
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/plwi_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// plwi_store: first-list posting memory
// One write port, one registered read port; a write to the address being
// read in the same cycle is forwarded to the read register.
// ----------------------------------------------------------------------------
module plwi_store (
    input  wire logic                      i_clk,
    input  wire plwi_pkg::t_store_wr       i_wr,
    input  wire logic [plwi_pkg::IDX_W-1:0] i_rd_addr,
    output plwi_pkg::t_entry               o_rd_data
);
    import plwi_pkg::*;

    t_entry mem [LIST_DEPTH];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port, write-first on address collision
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
            r_rd_data <= i_wr.data;
        end else begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ----- hw/rtl/plwi_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// plwi_ctrl: load, clear and probe sequencer
// Owns fill count and cursor, keeps the entry below the cursor in a register
// and walks the store one entry per cycle until the probe can be decided.
// ----------------------------------------------------------------------------
module plwi_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire plwi_pkg::t_cfg             i_cfg,
    input  wire logic                       i_in_valid,
    input  wire plwi_pkg::t_in_item         i_in,
    output logic                            o_in_stall,
    input  wire logic                       i_slot_free,
    output logic                            o_res_valid,
    output plwi_pkg::t_out_item             o_res,
    output plwi_pkg::t_store_wr             o_wr,
    output logic [plwi_pkg::IDX_W-1:0]      o_rd_addr,
    input  wire plwi_pkg::t_entry           i_rd_data
);
    import plwi_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_WALK_LT = 3'b010,
        ST_WALK_EQ = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cursor, n_cursor;
    logic [CNT_W-1:0]  r_count, n_count;
    t_entry            r_prev;
    t_in_item          r_probe;

    logic              acc;
    logic              clr_acc;
    logic              cur_ok, prev_ok, cur_same, prev_same;
    logic signed [24:0] d_cur, d_prev, left_x, right_x;
    logic              adv_lt, adv_eq, advance, walking, fin;
    logic              drop, matched, emit, mode_ok, word_ok, done;
    logic [15:0]       res_score;

    assign o_in_stall = (r_state != ST_IDLE);
    assign acc        = i_in_valid && (r_state == ST_IDLE);
    assign clr_acc    = acc && (i_in.req_type == REQ_CLEAR);

    // cursor and previous entry relations to the probe
    assign cur_ok    = (r_cursor < r_count);
    assign prev_ok   = (r_cursor != '0);
    assign cur_same  = cur_ok && (i_rd_data.doc == r_probe.doc_id);
    assign prev_same = prev_ok && (r_prev.doc == r_probe.doc_id);

    // position offsets probe minus stored
    assign d_cur   = $signed({1'b0, r_probe.position}) - $signed({1'b0, i_rd_data.pos});
    assign d_prev  = $signed({1'b0, r_probe.position}) - $signed({1'b0, r_prev.pos});
    assign left_x  = {{8{i_cfg.window_left[16]}}, i_cfg.window_left};
    assign right_x = {{8{i_cfg.window_right[16]}}, i_cfg.window_right};

    // walk conditions: smaller docs first, then same doc inside left bound
    assign adv_lt  = cur_ok && (i_rd_data.doc < r_probe.doc_id);
    assign adv_eq  = i_cfg.pos_check && cur_same && (d_cur >= left_x);
    assign walking = (r_state == ST_WALK_LT) || (r_state == ST_WALK_EQ);
    assign advance = ((r_state == ST_WALK_LT) && (adv_lt || adv_eq))
                  || ((r_state == ST_WALK_EQ) && adv_eq);
    assign fin     = walking && !advance;

    // outcome once the cursor rests
    always_comb begin
        drop      = 1'b0;
        matched   = 1'b0;
        res_score = r_probe.score;
        if (!i_cfg.pos_check) begin
            if (!cur_ok) begin
                drop = 1'b1;
            end else if (cur_same) begin
                matched   = 1'b1;
                res_score = combine_scores(i_cfg.score_mode, i_rd_data.score, r_probe.score);
            end
        end else begin
            priority if (prev_same) begin
                if (d_prev <= right_x) begin
                    matched   = 1'b1;
                    res_score = combine_scores(i_cfg.score_mode, r_prev.score, r_probe.score);
                end
            end else if (cur_same) begin
                // partner doc present but no predecessor inside it
                drop = 1'b1;
            end else begin
                // doc absent: past the end drops, otherwise a non-match
                drop = !cur_ok;
            end
        end
    end

    assign word_ok = (r_probe.word_id >= i_cfg.word_min) && (r_probe.word_id <= i_cfg.word_max);
    assign mode_ok = matched
        ? ((i_cfg.output_mode == OUT_MATCH) || (i_cfg.output_mode == OUT_BOTH))
        : ((i_cfg.output_mode == OUT_NONMATCH) || (i_cfg.output_mode == OUT_BOTH));
    assign emit    = !drop && word_ok && mode_ok;
    assign done    = fin && (!emit || i_slot_free);

    assign o_res_valid         = fin && emit && i_slot_free;
    assign o_res.out_doc       = r_probe.doc_id;
    assign o_res.out_word      = r_probe.word_id;
    assign o_res.out_position  = r_probe.position;
    assign o_res.out_score     = res_score;
    assign o_res.out_matched   = matched;

    // store write on load beats
    always_comb begin
        o_wr.en   = acc && (i_in.req_type == REQ_LOAD) && (r_count < CNT_W'(LIST_DEPTH));
        o_wr.addr = r_count[IDX_W-1:0];
        o_wr.data = '{doc: i_in.doc_id, pos: i_in.position, score: i_in.score};
    end

    // next state, cursor and count
    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_count  = r_count;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    unique case (i_in.req_type)
                        REQ_LOAD: begin
                            if (o_wr.en) begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        REQ_PROBE: n_state = ST_WALK_LT;
                        REQ_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK_LT, ST_WALK_EQ: begin
                if (advance) begin
                    n_cursor = r_cursor + CNT_W'(1);
                    if ((r_state == ST_WALK_LT) && !adv_lt) begin
                        n_state = ST_WALK_EQ;
                    end
                end else if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_rd_addr = n_cursor[IDX_W-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cursor <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_count  <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc && (i_in.req_type == REQ_PROBE)) begin
            r_probe <= i_in;
        end
        if (advance) begin
            r_prev <= i_rd_data;
        end
    end

    // cursor never passes the fill count
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("cursor beyond fill count");

    // fill count within store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_DEPTH))
        else $error("fill count beyond depth");

    // cursor only moves backward on a clear
    a_cursor_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clr_acc |=> r_cursor >= $past(r_cursor))
        else $error("cursor moved backward without clear");

endmodule
`default_nettype wire

// ----- hw/rtl/posting_list_window_intersect.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// posting_list_window_intersect: sorted posting list intersect engine
// Loads first-list postings into a store, then matches second-list probes
// against it with a forward cursor and an optional position window.
// ----------------------------------------------------------------------------
// Load and clear beats complete as they are taken. A probe is taken, then the
// cursor steps over the stored entries that it passes (one store read each on
// the single read port), and then the probe is decided; a decided result also
// waits while the output register is full and stalled. Input and output are
// decoupled by the output register, so a new beat is taken while a result is
// waiting. The store holds 1024 entries; loads past that are dropped, no
// clearing pass is needed after reset.
module posting_list_window_intersect (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire plwi_pkg::t_in_item                i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output plwi_pkg::t_out_item                    o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [plwi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [plwi_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import plwi_pkg::*;

    t_cfg          r_cfg;
    t_store_wr     wr;
    logic [IDX_W-1:0] rd_addr;
    t_entry        rd_data;
    logic          slot_free;
    logic          res_valid;
    t_out_item     res;
    logic          r_out_valid;
    t_out_item     r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_mode   <= SCORE_SUM;
            r_cfg.output_mode  <= OUT_MATCH;
            r_cfg.pos_check    <= 1'b0;
            r_cfg.window_left  <= '0;
            r_cfg.window_right <= '0;
            r_cfg.word_min     <= '0;
            r_cfg.word_max     <= WORD_MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCORE_MODE:   r_cfg.score_mode   <= i_cfg_data[0];
                CFG_OUTPUT_MODE:  r_cfg.output_mode  <= i_cfg_data[1:0];
                CFG_POS_CHECK:    r_cfg.pos_check    <= i_cfg_data[0];
                CFG_WINDOW_LEFT:  r_cfg.window_left  <= i_cfg_data[16:0];
                CFG_WINDOW_RIGHT: r_cfg.window_right <= i_cfg_data[16:0];
                CFG_WORD_MIN:     r_cfg.word_min     <= i_cfg_data[30:0];
                CFG_WORD_MAX:     r_cfg.word_max     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    plwi_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    plwi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_wr        (wr),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // output register
    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a result never overwrites a beat that is still held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !res_valid)
        else $error("result dropped onto held output");

endmodule
`default_nettype wire
